// ===== hdl/cfdl_pkg.sv =====
// Shared types and constants for the crossfading delay line.
package cfdl_pkg;

    // Default sizes
    localparam int DEPTH_DEF        = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int WEIGHT_W    = 17;
    localparam int FADE_W      = 16;
    localparam int DELAY_REQ_W = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 17'h00000;

    // Register indexes (byte address / 4)
    localparam logic REG_FADE_LENGTH = 1'b0;
    localparam logic REG_FADE_STEP   = 1'b1;

    // Item kinds carried on tuser
    localparam logic KIND_SAMPLE    = 1'b0;
    localparam logic KIND_SET_DELAY = 1'b1;

    // Per-beat control that travels with the ring read data into the mixer
    typedef struct packed {
        logic                vld;
        logic                old_ok;
        logic                new_ok;
        logic [WEIGHT_W-1:0] w_old;
        logic [WEIGHT_W-1:0] w_new;
    } tap_ctl_t;

endpackage

// ===== hdl/cfdl_regs.sv =====
// APB register file: fade length and fade step.
module cfdl_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cfdl_pkg::APB_AW-1:0]      paddr,
    input  logic [cfdl_pkg::APB_DW-1:0]      pwdata,
    output logic [cfdl_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output logic [cfdl_pkg::FADE_W-1:0]      fade_length,
    output logic [cfdl_pkg::WEIGHT_W-1:0]    fade_step
);

    logic [cfdl_pkg::FADE_W-1:0]   fade_length_reg;
    logic [cfdl_pkg::WEIGHT_W-1:0] fade_step_reg;
    logic                          wr_en;
    logic                          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_length_reg <= cfdl_pkg::FADE_W'(1);
            fade_step_reg   <= cfdl_pkg::WEIGHT_ONE;
        end else if (wr_en) begin
            unique case (reg_idx)
                cfdl_pkg::REG_FADE_LENGTH: fade_length_reg <= pwdata[cfdl_pkg::FADE_W-1:0];
                cfdl_pkg::REG_FADE_STEP:   fade_step_reg   <= pwdata[cfdl_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            cfdl_pkg::REG_FADE_LENGTH: prdata = cfdl_pkg::APB_DW'(fade_length_reg);
            cfdl_pkg::REG_FADE_STEP:   prdata = cfdl_pkg::APB_DW'(fade_step_reg);
            default:                   prdata = '0;
        endcase
    end

    assign fade_length = fade_length_reg;
    assign fade_step   = fade_step_reg;

endmodule

// ===== hdl/cfdl_ring.sv =====
// Ring store: one write port, two registered read ports, read-old on collision.
module cfdl_ring #(
    parameter int DEPTH        = cfdl_pkg::DEPTH_DEF,
    parameter int SAMPLE_WIDTH = cfdl_pkg::SAMPLE_WIDTH_DEF,
    localparam int AW          = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic [SAMPLE_WIDTH-1:0] wdata,
    input  logic [AW-1:0]           raddr_a,
    input  logic [AW-1:0]           raddr_b,
    output logic [SAMPLE_WIDTH-1:0] rdata_a,
    output logic [SAMPLE_WIDTH-1:0] rdata_b
);

    logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic [SAMPLE_WIDTH-1:0] rdata_a_reg;
    logic [SAMPLE_WIDTH-1:0] rdata_b_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, held while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hdl/cfdl_mix.sv =====
// Mixer: weight multiply, sum, round and saturate, ending in the output register.
module cfdl_mix #(
    parameter int SAMPLE_WIDTH = cfdl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  cfdl_pkg::tap_ctl_t      ctl,
    input  logic [SAMPLE_WIDTH-1:0] tap_old_raw,
    input  logic [SAMPLE_WIDTH-1:0] tap_new_raw,
    output logic                    out_valid,
    output logic [SAMPLE_WIDTH-1:0] out_data
);

    localparam int PW  = SAMPLE_WIDTH + cfdl_pkg::WEIGHT_W + 1;
    localparam int SUMW = PW + 1;
    localparam int RW  = SUMW - 16;
    localparam logic signed [SUMW-1:0] RND  = SUMW'(32768);
    localparam logic signed [RW-1:0]   MAXV =
        RW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0]   MINV = -MAXV - RW'(1);

    logic signed [SAMPLE_WIDTH-1:0] tap_old;
    logic signed [SAMPLE_WIDTH-1:0] tap_new;
    logic signed [PW-1:0]           prod_old;
    logic signed [PW-1:0]           prod_new;
    logic signed [PW-1:0]           prod_old_reg;
    logic signed [PW-1:0]           prod_new_reg;
    logic                           prod_vld_reg;
    logic signed [SUMW-1:0]         acc;
    logic signed [RW-1:0]           rnd;
    logic signed [SAMPLE_WIDTH-1:0] sat;
    logic                           out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]        out_data_reg;

    // Never-written slots read as zero
    always_comb begin
        tap_old  = ctl.old_ok ? $signed(tap_old_raw) : '0;
        tap_new  = ctl.new_ok ? $signed(tap_new_raw) : '0;
        prod_old = PW'($signed({1'b0, ctl.w_old})) * PW'(tap_old);
        prod_new = PW'($signed({1'b0, ctl.w_new})) * PW'(tap_new);
    end

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (adv) begin
            prod_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_old_reg <= prod_old;
            prod_new_reg <= prod_new;
        end
    end

    // Sum, round half up (floor after bias), saturate
    always_comb begin
        acc = SUMW'(prod_old_reg) + SUMW'(prod_new_reg) + RND;
        rnd = acc[SUMW-1:16];
        if (rnd > MAXV) begin
            sat = MAXV[SAMPLE_WIDTH-1:0];
        end else if (rnd < MINV) begin
            sat = MINV[SAMPLE_WIDTH-1:0];
        end else begin
            sat = rnd[SAMPLE_WIDTH-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/crossfading_delay_line.sv =====
// Top level of the crossfading delay line: delay/fade control and stream handshake.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready. s_tuser is the kind: 0 carries an
//   audio sample in s_tdata, 1 sets a new delay (s_tdata upper field). A sample
//   beat yields one beat on m_tvalid/m_tready; a set-delay beat yields none and
//   starts a crossfade of fade_length samples from the old to the new tap.
//   fade_length (0x0) and fade_step (0x4) are written over the APB port; the
//   user must write them while the block is idle; the block does not check it.
// Throughput: one input beat per cycle while the output is not stalled. Each
//   sample issues both tap reads and its write to the ring memory in the accept
//   cycle (one write port, two read ports), so the ring does not limit the rate.
// Pipeline: an accepted sample passes the memory read register, the product
//   register and the output register, in that order, before it is on m_tdata.
// Reset: control and delays clear, weights go to one and zero; slots never
//   written read as zero through a fill count, so no clearing pass is needed.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready is low; the block resumes without loss when m_tready returns.
module crossfading_delay_line #(
    parameter int DEPTH        = cfdl_pkg::DEPTH_DEF,
    parameter int SAMPLE_WIDTH = cfdl_pkg::SAMPLE_WIDTH_DEF,
    localparam int IN_TW       = ((SAMPLE_WIDTH + cfdl_pkg::DELAY_REQ_W + 7) / 8) * 8,
    localparam int OUT_TW      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_TW-1:0]              s_tdata,   // sample_in, delay_request
    input  logic                          s_tuser,   // kind
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_TW-1:0]             m_tdata,   // sample_out
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfdl_pkg::APB_AW-1:0]   paddr,
    input  logic [cfdl_pkg::APB_DW-1:0]   pwdata,
    output logic [cfdl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int WW = cfdl_pkg::WEIGHT_W;
    localparam logic [FW-1:0] FILL_FULL  = FW'(DEPTH);
    localparam logic [AW-1:0] POS_LAST   = AW'(DEPTH - 1);
    localparam logic [16:0]   DEPTH_WIDE = 17'(DEPTH);

    logic [cfdl_pkg::FADE_W-1:0] fade_length;
    logic [WW-1:0]               fade_step;

    logic [AW-1:0]               wr_pos_reg,  wr_pos_next;
    logic [FW-1:0]               fill_reg,    fill_next;
    logic [AW-1:0]               cur_dly_reg, cur_dly_next;
    logic [AW-1:0]               tgt_dly_reg, tgt_dly_next;
    logic [WW-1:0]               w_old_reg,   w_old_next;
    logic [WW-1:0]               w_new_reg,   w_new_next;
    logic [cfdl_pkg::FADE_W-1:0] fade_rem_reg, fade_rem_next;
    cfdl_pkg::tap_ctl_t          ctl_reg,     ctl_next;

    logic                          adv;
    logic                          accept;
    logic                          is_sample;
    logic [SAMPLE_WIDTH-1:0]       sample_in;
    logic [cfdl_pkg::DELAY_REQ_W-1:0] delay_request;
    logic [AW-1:0]                 req_clamped;
    logic [AW-1:0]                 addr_old;
    logic [AW-1:0]                 addr_new;
    logic [WW:0]                   w_new_sum;
    logic [SAMPLE_WIDTH-1:0]       tap_old_raw;
    logic [SAMPLE_WIDTH-1:0]       tap_new_raw;
    logic                          out_valid;
    logic [SAMPLE_WIDTH-1:0]       sample_out;

    // Configuration registers
    cfdl_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fade_length (fade_length),
        .fade_step   (fade_step)
    );

    // Handshake: the whole pipeline moves whenever the output slot frees up
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && s_tready;
    assign is_sample = (s_tuser == cfdl_pkg::KIND_SAMPLE);

    assign sample_in     = s_tdata[SAMPLE_WIDTH-1:0];
    assign delay_request = s_tdata[SAMPLE_WIDTH +: cfdl_pkg::DELAY_REQ_W];

    // Tap addresses: d slots before the last written one, modulo DEPTH
    function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] pos,
                                               input logic [AW-1:0] dly);
        logic [AW:0] sum;
        begin
            if (pos >= dly) begin
                sum = {1'b0, pos} - {1'b0, dly};
            end else begin
                sum = {1'b0, pos} + (AW + 1)'(DEPTH) - {1'b0, dly};
            end
            return sum[AW-1:0];
        end
    endfunction

    always_comb begin
        addr_old = tap_addr(wr_pos_reg, cur_dly_reg);
        addr_new = tap_addr(wr_pos_reg, tgt_dly_reg);
        if ({1'b0, delay_request} >= DEPTH_WIDE) begin
            req_clamped = POS_LAST;
        end else begin
            req_clamped = delay_request[AW-1:0];
        end
        w_new_sum = {1'b0, w_new_reg} + {1'b0, fade_step};
    end

    // Next state for delays, weights and write position
    always_comb begin
        wr_pos_next   = wr_pos_reg;
        fill_next     = fill_reg;
        cur_dly_next  = cur_dly_reg;
        tgt_dly_next  = tgt_dly_reg;
        w_old_next    = w_old_reg;
        w_new_next    = w_new_reg;
        fade_rem_next = fade_rem_reg;

        ctl_next.vld    = accept && is_sample;
        ctl_next.old_ok = {1'b0, cur_dly_reg} < fill_reg;
        ctl_next.new_ok = {1'b0, tgt_dly_reg} < fill_reg;
        ctl_next.w_old  = w_old_reg;
        ctl_next.w_new  = w_new_reg;

        if (accept && !is_sample) begin
            cur_dly_next  = tgt_dly_reg;
            tgt_dly_next  = req_clamped;
            w_old_next    = cfdl_pkg::WEIGHT_ONE;
            w_new_next    = cfdl_pkg::WEIGHT_ZERO;
            fade_rem_next = (fade_length == '0) ? cfdl_pkg::FADE_W'(1) : fade_length;
        end else if (accept) begin
            wr_pos_next = (wr_pos_reg == POS_LAST) ? '0 : wr_pos_reg + AW'(1);
            if (fill_reg != FILL_FULL) begin
                fill_next = fill_reg + FW'(1);
            end
            if (fade_rem_reg != '0) begin
                w_old_next = (w_old_reg > fade_step) ? w_old_reg - fade_step
                                                     : cfdl_pkg::WEIGHT_ZERO;
                w_new_next = (w_new_sum > {1'b0, cfdl_pkg::WEIGHT_ONE})
                           ? cfdl_pkg::WEIGHT_ONE : w_new_sum[WW-1:0];
                fade_rem_next = fade_rem_reg - cfdl_pkg::FADE_W'(1);
                // Last sample of the fade: the new tap becomes the current one
                if (fade_rem_reg == cfdl_pkg::FADE_W'(1)) begin
                    cur_dly_next = tgt_dly_reg;
                    w_old_next   = cfdl_pkg::WEIGHT_ONE;
                    w_new_next   = cfdl_pkg::WEIGHT_ZERO;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pos_reg   <= '0;
            fill_reg     <= '0;
            cur_dly_reg  <= '0;
            tgt_dly_reg  <= '0;
            w_old_reg    <= cfdl_pkg::WEIGHT_ONE;
            w_new_reg    <= cfdl_pkg::WEIGHT_ZERO;
            fade_rem_reg <= '0;
            ctl_reg      <= '0;
        end else begin
            wr_pos_reg   <= wr_pos_next;
            fill_reg     <= fill_next;
            cur_dly_reg  <= cur_dly_next;
            tgt_dly_reg  <= tgt_dly_next;
            w_old_reg    <= w_old_next;
            w_new_reg    <= w_new_next;
            fade_rem_reg <= fade_rem_next;
            if (adv) begin
                ctl_reg <= ctl_next;
            end
        end
    end

    // Ring memory: taps read with the pre-write position, sample written after
    cfdl_ring #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ring (
        .aclk    (aclk),
        .en      (adv),
        .we      (accept && is_sample),
        .waddr   (wr_pos_next),
        .wdata   (sample_in),
        .raddr_a (addr_old),
        .raddr_b (addr_new),
        .rdata_a (tap_old_raw),
        .rdata_b (tap_new_raw)
    );

    // Weighted mix and output register
    cfdl_mix #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .ctl         (ctl_reg),
        .tap_old_raw (tap_old_raw),
        .tap_new_raw (tap_new_raw),
        .out_valid   (out_valid),
        .out_data    (sample_out)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_TW'(sample_out);

`ifndef NO_ASSERTIONS
    // Outside a fade the weights sit at one and zero
    a_idle_weights: assert property (@(posedge aclk) disable iff (!aresetn)
        (fade_rem_reg == '0) |-> (w_old_reg == cfdl_pkg::WEIGHT_ONE &&
                                  w_new_reg == cfdl_pkg::WEIGHT_ZERO))
        else $error("weights not reset outside a fade");

    // The two weights never add up to more than one
    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, w_old_reg} + {1'b0, w_new_reg}) <= {1'b0, cfdl_pkg::WEIGHT_ONE})
        else $error("weight sum above one");

    // Each accepted sample moves the write position by one slot
    a_wr_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_sample) |=>
            (wr_pos_reg == (($past(wr_pos_reg) == POS_LAST) ? '0
                                                            : $past(wr_pos_reg) + AW'(1))))
        else $error("write position did not advance");

    // A set-delay beat leaves the write position and fill count alone
    a_set_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_sample) |=> ($stable(wr_pos_reg) && $stable(fill_reg)))
        else $error("set-delay beat touched the ring");
`endif

endmodule
